### src/window_slot_and_stack_manager_unit_defines.svh
// Assertion macros shared by the window slot manager checker.
`ifndef WINDOW_SLOT_AND_STACK_MANAGER_UNIT_DEFINES_SVH
`define WINDOW_SLOT_AND_STACK_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define WSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define WSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/wssm_pkg.sv
// Shared types and constants of the window slot and stack manager.
`default_nettype none
package wssm_pkg;

  // Pool size and derived widths (slot field is fixed at three bits)
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;

  // Operation codes
  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_FRONT   = 2'd2
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Kind of pass over the stacking list
  typedef enum logic {
    WALK_INSERT = 1'b0,
    WALK_REMOVE = 1'b1
  } walk_t;

  // Command from the controller to the stack walker
  typedef struct packed {
    logic              start;
    walk_t             kind;
    logic [SLOT_W-1:0] key;
    logic [CNT_W-1:0]  count;
  } wssm_cmd_t;

  // Response from the stack walker
  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] top;
  } wssm_rsp_t;

endpackage
`default_nettype wire

### src/wssm_stack.sv
// Stacking list storage and its one-entry-per-cycle walk engine.
`default_nettype none
module wssm_stack
  import wssm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire wssm_cmd_t cmd,
  output wssm_rsp_t      rsp
);

  logic [SLOT_W-1:0] order [SLOT_COUNT];
  logic              active;
  walk_t             kind;
  logic [SLOT_W-1:0] key;
  logic [SLOT_W-1:0] carry;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_prev;
  logic              found;
  logic [SLOT_W-1:0] cur;
  logic              hit;
  logic              last;

  // One read and the shared comparator per cycle
  assign cur      = order[idx[SLOT_W-1:0]];
  assign hit      = (cur == key);
  assign idx_prev = idx - 1'b1;

  // Insert stops on the key or at the list end; remove runs to the end
  always_comb begin
    if (kind == WALK_INSERT) begin
      last = hit || (idx == count);
    end else begin
      last = (idx == count - 1'b1);
    end
  end

  assign rsp.done = active && last;
  assign rsp.top  = order[0];

  // Walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.start) begin
      active <= 1'b1;
    end else if (active && last) begin
      active <= 1'b0;
    end
  end

  // Walk datapath: insert ripples a carry down, remove closes the gap upward
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind  <= cmd.kind;
      key   <= cmd.key;
      count <= cmd.count;
      carry <= cmd.key;
      idx   <= '0;
      found <= 1'b0;
    end else if (active) begin
      idx <= idx + 1'b1;
      case (kind)
        WALK_INSERT: begin
          order[idx[SLOT_W-1:0]] <= carry;
          carry                  <= cur;
        end
        default: begin
          if (found) begin
            order[idx_prev[SLOT_W-1:0]] <= cur;
          end
          found <= found | hit;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### src/window_slot_and_stack_manager_unit.sv
// Top level of the window slot allocator with a front-to-back stacking list.
// One word is taken at a time. Create, destroy and bring-to-front of a busy
// slot walk the stacking list one entry per cycle through a single compare
// unit: create walks count+1 entries, destroy walks count entries, and
// bring-to-front walks up to the slot's position plus one. Pool-full and
// ignored operations skip the walk and show their result in the next cycle.
// in_ready is high again in the cycle after the result word is taken.
`default_nettype none
module window_slot_and_stack_manager_unit
  import wssm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        operation,
  input  wire logic [SLOT_W-1:0] slot,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [SLOT_W-1:0]      slot_id,
  output logic [CNT_W-1:0]       window_count,
  output logic [SLOT_W-1:0]      top_slot,
  output logic                   top_valid
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t            state;
  logic [SLOT_COUNT-1:0] busy;
  logic [CNT_W-1:0]  live_count;
  logic [1:0]        status_r;
  logic [SLOT_W-1:0] slot_id_r;

  logic              accept;
  logic [SLOT_W-1:0] free_slot;
  logic              free_any;
  logic              do_walk;
  walk_t             walk_kind;
  logic [SLOT_W-1:0] walk_key;
  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_id;
  wssm_cmd_t         cmd;
  wssm_rsp_t         rsp;

  assign accept = in_valid && in_ready;

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end
  assign free_any = ~&busy;

  // Decode of the incoming word; every slot code lies inside the pool
  always_comb begin
    do_walk    = 1'b0;
    walk_kind  = WALK_INSERT;
    walk_key   = slot;
    res_status = ST_IGNORED;
    res_id     = slot;
    case (operation)
      OP_CREATE: begin
        if (free_any) begin
          do_walk    = 1'b1;
          walk_key   = free_slot;
          res_status = ST_DONE;
          res_id     = free_slot;
        end else begin
          res_status = ST_FULL;
          res_id     = '0;
        end
      end
      OP_DESTROY: begin
        if (busy[slot]) begin
          do_walk    = 1'b1;
          walk_kind  = WALK_REMOVE;
          res_status = ST_DONE;
        end
      end
      OP_FRONT: begin
        if (busy[slot]) begin
          do_walk    = 1'b1;
          res_status = ST_DONE;
        end
      end
      default: begin
        do_walk = 1'b0;
      end
    endcase
  end

  // Walker command; count is the list length before this operation
  assign cmd.start = accept && do_walk;
  assign cmd.kind  = walk_kind;
  assign cmd.key   = walk_key;
  assign cmd.count = live_count;

  wssm_stack u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // Sequencer, pool bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= '0;
      live_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_walk) begin
              state <= S_WALK;
              if (operation == OP_CREATE) begin
                busy[free_slot] <= 1'b1;
                live_count      <= live_count + 1'b1;
              end else if (operation == OP_DESTROY) begin
                busy[slot] <= 1'b0;
                live_count <= live_count - 1'b1;
              end
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_WALK: begin
          if (rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload held from acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= res_status;
      slot_id_r <= res_id;
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign status       = status_r;
  assign slot_id      = slot_id_r;
  assign window_count = live_count;
  assign top_valid    = (live_count != '0);
  assign top_slot     = top_valid ? rsp.top : '0;

endmodule
`default_nettype wire

### src/wssm_checker.sv
// Port-level checker of the window slot manager, bound to the top level.
`default_nettype none
`include "window_slot_and_stack_manager_unit_defines.svh"
module wssm_checker
  import wssm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [1:0]        operation,
  input wire logic [SLOT_W-1:0] slot,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        status,
  input wire logic [SLOT_W-1:0] slot_id,
  input wire logic [CNT_W-1:0]  window_count,
  input wire logic [SLOT_W-1:0] top_slot,
  input wire logic              top_valid
);

  // Front flag agrees with the count
  `WSSM_ASSERT_NOW(a_top_valid, out_valid, top_valid == (window_count != '0), "top_valid mismatch")

  // Full report only with every slot busy, and with slot zero
  `WSSM_ASSERT_NOW(a_full, out_valid && status == ST_FULL, window_count == CNT_W'(SLOT_COUNT) && slot_id == '0, "bad full result")

  // One word in flight: not ready while a result is shown
  `WSSM_ASSERT_NOW(a_one_word, out_valid, !in_ready, "ready while result pending")

  // Busy after a word is taken
  `WSSM_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready straight after accept")

  // Result is dropped once taken
  `WSSM_ASSERT_NEXT(a_drop, out_valid && out_ready, !out_valid, "result repeated")

endmodule

bind window_slot_and_stack_manager_unit wssm_checker u_wssm_checker (.*);
`default_nettype wire
